@@ rtl/wcsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcsp_pkg
// Shared types, codes and constants for the WAV chunk stream parser.
// ----------------------------------------------------------------------------
package wcsp_pkg;

  // "data" chunk tag, little-endian as assembled from the byte stream
  localparam logic [31:0] TAG_DATA  = 32'h6174_6164;
  localparam logic [31:0] FMT_BASE  = 32'd16;
  // last count of the leading marker bytes (16 bytes, counted from zero)
  localparam logic [31:0] LEAD_LAST = 32'd15;
  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] BITS_8    = 16'd8;
  localparam logic [15:0] BITS_16   = 16'd16;
  localparam logic [15:0] BITS_32   = 16'd32;
  localparam int          DIV_STEPS = 32;

  localparam logic [1:0] STAT_SUCCESS     = 2'd0;
  localparam logic [1:0] STAT_CORRUPT     = 2'd1;
  localparam logic [1:0] STAT_UNSUPPORTED = 2'd2;
  localparam logic [1:0] STAT_NO_DATA     = 2'd3;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef enum logic [4:0] {
    ST_LEAD, ST_FMTLEN, ST_FTYPE, ST_CHANS, ST_RATE, ST_BRATE, ST_ALIGN, ST_BITS,
    ST_FMTSKIP, ST_CHUNKID, ST_CHUNKSIZE, ST_CHUNKSKIP, ST_DATA, ST_DRAIN,
    ST_MUL, ST_CHK, ST_DIV1, ST_DIV2, ST_HDR, ST_NODATA
  } state_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_FMTLEN, DST_FTYPE, DST_CHANS, DST_RATE, DST_BRATE,
    DST_ALIGN, DST_BITS, DST_TAG, DST_SIZE
  } dst_t;

  typedef enum logic [2:0] {
    CNT_HOLD, CNT_INC, CNT_CLR, CNT_DEC, CNT_FMT, CNT_SIZE, CNT_PLEN
  } cnt_op_t;

  typedef enum logic [1:0] {
    OUT_NONE, OUT_DATA, OUT_HDR, OUT_NODATA
  } out_sel_t;

  typedef struct packed {
    logic       take;
    logic       len4;
    dst_t       dst;
    cnt_op_t    cnt_op;
    logic       mul_ld;
    logic       div_start;
    logic       div_sel;
    logic       stat_ld;
    logic [1:0] stat_val;
    logic       plen_ld;
    logic       plen_clr;
    out_sel_t   out_sel;
    logic       last;
    logic       clear_all;
  } cmd_t;

  typedef struct packed {
    logic field_done;
    logic lead_done;
    logic rem_one;
    logic fmt_rem_zero;
    logic size_zero;
    logic tag_is_data;
    logic fbits_zero;
    logic div_done;
    logic div_rem_zero;
    logic unsup;
    logic plen_zero;
    logic out_ready;
  } stat_t;

endpackage

@@ rtl/wav_chunk_stream_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_chunk_stream_parser
// Byte-serial RIFF/WAV header parser with header report and payload forwarding.
// ----------------------------------------------------------------------------
// The block takes one file byte per beat and sustains one byte per cycle while
// it walks the leading markers, the fmt fields, skipped chunks and the data
// payload. At the byte that completes the data chunk header it stops taking
// beats: the multiply state forms the frame size with a 16x16 multiplier,
// then a shared 32-step serial divider checks frame evenness and a second
// 32-step pass gives the whole-frame payload length. The header beat
// (kind 0) then leaves through the result register, followed by one kind 1
// beat per payload byte. A result waiting in the output register does not
// hold up input unless it is stalled. Any byte marked end_of_stream returns
// the block to its reset state, after a no-data report if no data chunk was
// seen.
module wav_chunk_stream_parser
  import wcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  status,
  output logic [15:0] format_code,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [31:0] byte_rate,
  output logic [15:0] block_align,
  output logic [15:0] sample_bits,
  output logic [31:0] payload_length,
  output logic [7:0]  data_byte,
  output logic        last
);

  cmd_t  cmd;
  stat_t sts;

  // sequencer: phase tracking, header check steps, input flow
  wcsp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .end_of_stream (end_of_stream),
    .sts           (sts),
    .cmd           (cmd)
  );

  // datapath: field registers, counter, divider and result register
  wcsp_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .status         (status),
    .format_code    (format_code),
    .channel_count  (channel_count),
    .sample_rate    (sample_rate),
    .byte_rate      (byte_rate),
    .block_align    (block_align),
    .sample_bits    (sample_bits),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .last           (last)
  );

endmodule

@@ rtl/wcsp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcsp_div
// Serial restoring divider, one quotient bit per cycle; gives the remainder.
// ----------------------------------------------------------------------------
module wcsp_div
  import wcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic        busy;
  logic [4:0]  step_cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [32:0] rem_shift;
  logic [32:0] diff;
  logic        ge;

  assign rem_shift = {rem, quo[31]};
  assign diff      = rem_shift - {1'b0, divisor};
  assign ge        = rem_shift >= {1'b0, divisor};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + 5'd1;
        if (step_cnt == 5'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : rem_shift[31:0];
      quo <= {quo[30:0], ge};
    end
  end

endmodule

@@ rtl/wcsp_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcsp_dpath
// Field assembly, held header fields, byte counter, validation and result register.
// ----------------------------------------------------------------------------
module wcsp_dpath
  import wcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       sts,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  status,
  output logic [15:0] format_code,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [31:0] byte_rate,
  output logic [15:0] block_align,
  output logic [15:0] sample_bits,
  output logic [31:0] payload_length,
  output logic [7:0]  data_byte,
  output logic        last
);

  logic [1:0]  byte_in_field;
  logic [31:0] field_acc;
  logic [31:0] bytes_remaining;
  logic [31:0] chunk_tag;
  logic [31:0] fmt_length;
  logic [15:0] fmt_code;
  logic [15:0] channels_held;
  logic [31:0] rate_held;
  logic [31:0] byte_rate_held;
  logic [15:0] align_held;
  logic [15:0] bits_held;
  logic [31:0] size_hold;
  logic [31:0] frame_bits;
  logic [1:0]  stat_reg;
  logic [31:0] plen;

  logic [31:0] byte_ext;
  logic [31:0] fval;
  logic        field_done;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [31:0] div_rem;
  logic        out_ready;

  assign byte_ext   = {24'd0, in_byte};
  assign fval       = field_acc | (byte_ext << {byte_in_field, 3'b000});
  assign field_done = cmd.len4 ? (byte_in_field == 2'd3) : (byte_in_field != 2'd0);
  assign out_ready  = !out_valid || !out_stall;

  // frame % channels first, then size % frame
  assign div_dividend = cmd.div_sel ? size_hold : {3'd0, frame_bits[31:3]};
  assign div_divisor  = cmd.div_sel ? {3'd0, frame_bits[31:3]} : {16'd0, channels_held};

  wcsp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    sts.field_done   = field_done;
    sts.lead_done    = bytes_remaining == LEAD_LAST;
    sts.rem_one      = bytes_remaining == 32'd1;
    sts.fmt_rem_zero = fmt_length == FMT_BASE;
    sts.size_zero    = fval == 32'd0;
    sts.tag_is_data  = chunk_tag == TAG_DATA;
    sts.fbits_zero   = frame_bits == 32'd0;
    sts.div_done     = div_done;
    sts.div_rem_zero = div_rem == 32'd0;
    sts.unsup        = (fmt_code != FMT_PCM) ||
                       !((bits_held == BITS_8) || (bits_held == BITS_16) ||
                         (bits_held == BITS_32));
    sts.plen_zero    = plen == 32'd0;
    sts.out_ready    = out_ready;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      byte_in_field   <= '0;
      field_acc       <= '0;
      bytes_remaining <= '0;
      chunk_tag       <= '0;
      fmt_length      <= '0;
      fmt_code        <= '0;
      channels_held   <= '0;
      rate_held       <= '0;
      byte_rate_held  <= '0;
      align_held      <= '0;
      bits_held       <= '0;
    end else begin
      if (cmd.take) begin
        if (field_done) begin
          field_acc     <= '0;
          byte_in_field <= '0;
          case (cmd.dst)
            DST_FMTLEN: fmt_length     <= fval;
            DST_FTYPE:  fmt_code       <= fval[15:0];
            DST_CHANS:  channels_held  <= fval[15:0];
            DST_RATE:   rate_held      <= fval;
            DST_BRATE:  byte_rate_held <= fval;
            DST_ALIGN:  align_held     <= fval[15:0];
            DST_BITS:   bits_held      <= fval[15:0];
            DST_TAG:    chunk_tag      <= fval;
            default: ;
          endcase
        end else begin
          field_acc     <= fval;
          byte_in_field <= byte_in_field + 2'd1;
        end
      end
      case (cmd.cnt_op)
        CNT_INC:  bytes_remaining <= bytes_remaining + 32'd1;
        CNT_CLR:  bytes_remaining <= '0;
        CNT_DEC:  bytes_remaining <= bytes_remaining - 32'd1;
        CNT_FMT:  bytes_remaining <= fmt_length - FMT_BASE;
        CNT_SIZE: bytes_remaining <= fval;
        CNT_PLEN: bytes_remaining <= plen;
        default: ;
      endcase
    end
  end

  // header evaluation
  always_ff @(posedge clk) begin
    if (cmd.take && field_done && cmd.dst == DST_SIZE) begin
      size_hold <= fval;
    end
    if (cmd.mul_ld) begin
      frame_bits <= {16'd0, channels_held} * {16'd0, bits_held};
    end
    if (cmd.stat_ld) begin
      stat_reg <= cmd.stat_val;
    end
    if (cmd.plen_clr) begin
      plen <= '0;
    end else if (cmd.plen_ld) begin
      plen <= size_hold - div_rem;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_sel != OUT_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_sel != OUT_NONE) begin
      format_code   <= fmt_code;
      channel_count <= channels_held;
      sample_rate   <= rate_held;
      byte_rate     <= byte_rate_held;
      block_align   <= align_held;
      sample_bits   <= bits_held;
      last          <= cmd.last;
      case (cmd.out_sel)
        OUT_DATA: begin
          kind           <= KIND_DATA;
          status         <= STAT_SUCCESS;
          payload_length <= '0;
          data_byte      <= in_byte;
        end
        OUT_HDR: begin
          kind           <= KIND_HEADER;
          status         <= stat_reg;
          payload_length <= plen;
          data_byte      <= '0;
        end
        default: begin
          kind           <= KIND_HEADER;
          status         <= STAT_NO_DATA;
          payload_length <= '0;
          data_byte      <= '0;
        end
      endcase
    end
  end

endmodule

@@ rtl/wcsp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcsp_ctrl
// Parse sequencer: walks the header phases and runs the header check.
// ----------------------------------------------------------------------------
module wcsp_ctrl
  import wcsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  end_of_stream,
  input  stat_t sts,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   eos_hold;
  logic   eos_hold_next;
  logic   parse;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LEAD;
      eos_hold <= 1'b0;
    end else begin
      state    <= state_next;
      eos_hold <= eos_hold_next;
    end
  end

  always_comb begin
    case (state)
      ST_MUL, ST_CHK, ST_DIV1, ST_DIV2, ST_HDR, ST_NODATA: parse = 1'b0;
      default:                                           parse = 1'b1;
    endcase
    in_stall = !(parse && sts.out_ready);
    accept   = in_valid && !in_stall;

    state_next    = state;
    eos_hold_next = eos_hold;
    cmd.take      = 1'b0;
    cmd.len4      = 1'b0;
    cmd.dst       = DST_NONE;
    cmd.cnt_op    = CNT_HOLD;
    cmd.mul_ld    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = 1'b0;
    cmd.stat_ld   = 1'b0;
    cmd.stat_val  = STAT_SUCCESS;
    cmd.plen_ld   = 1'b0;
    cmd.plen_clr  = 1'b0;
    cmd.out_sel   = OUT_NONE;
    cmd.last      = 1'b0;
    cmd.clear_all = 1'b0;

    case (state)
      ST_LEAD: begin
        if (accept) begin
          cmd.cnt_op = CNT_INC;
          if (sts.lead_done) begin
            cmd.cnt_op = CNT_CLR;
            state_next = ST_FMTLEN;
          end
        end
      end
      ST_FMTLEN, ST_RATE, ST_BRATE, ST_CHUNKID: begin
        if (accept) begin
          cmd.take = 1'b1;
          cmd.len4 = 1'b1;
          case (state)
            ST_FMTLEN: begin
              cmd.dst = DST_FMTLEN;
              if (sts.field_done) state_next = ST_FTYPE;
            end
            ST_RATE: begin
              cmd.dst = DST_RATE;
              if (sts.field_done) state_next = ST_BRATE;
            end
            ST_BRATE: begin
              cmd.dst = DST_BRATE;
              if (sts.field_done) state_next = ST_ALIGN;
            end
            default: begin
              cmd.dst = DST_TAG;
              if (sts.field_done) state_next = ST_CHUNKSIZE;
            end
          endcase
        end
      end
      ST_FTYPE, ST_CHANS, ST_ALIGN: begin
        if (accept) begin
          cmd.take = 1'b1;
          case (state)
            ST_FTYPE: begin
              cmd.dst = DST_FTYPE;
              if (sts.field_done) state_next = ST_CHANS;
            end
            ST_CHANS: begin
              cmd.dst = DST_CHANS;
              if (sts.field_done) state_next = ST_RATE;
            end
            default: begin
              cmd.dst = DST_ALIGN;
              if (sts.field_done) state_next = ST_BITS;
            end
          endcase
        end
      end
      ST_BITS: begin
        if (accept) begin
          cmd.take = 1'b1;
          cmd.dst  = DST_BITS;
          if (sts.field_done) begin
            cmd.cnt_op = CNT_FMT;
            state_next = sts.fmt_rem_zero ? ST_CHUNKID : ST_FMTSKIP;
          end
        end
      end
      ST_FMTSKIP, ST_CHUNKSKIP: begin
        if (accept) begin
          cmd.cnt_op = CNT_DEC;
          if (sts.rem_one) state_next = ST_CHUNKID;
        end
      end
      ST_CHUNKSIZE: begin
        if (accept) begin
          cmd.take = 1'b1;
          cmd.len4 = 1'b1;
          if (sts.field_done) begin
            if (sts.tag_is_data) begin
              cmd.dst       = DST_SIZE;
              eos_hold_next = end_of_stream;
              state_next    = ST_MUL;
            end else begin
              cmd.cnt_op = CNT_SIZE;
              state_next = sts.size_zero ? ST_CHUNKID : ST_CHUNKSKIP;
            end
          end
        end
      end
      ST_DATA: begin
        if (accept) begin
          cmd.cnt_op  = CNT_DEC;
          cmd.out_sel = OUT_DATA;
          cmd.last    = sts.rem_one || end_of_stream;
          if (sts.rem_one) state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: ;
      ST_MUL: begin
        cmd.mul_ld   = 1'b1;
        cmd.plen_clr = 1'b1;
        state_next   = ST_CHK;
      end
      ST_CHK: begin
        if (sts.fbits_zero) begin
          cmd.stat_ld  = 1'b1;
          cmd.stat_val = STAT_CORRUPT;
          state_next   = ST_HDR;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (sts.div_done) begin
          if (!sts.div_rem_zero) begin
            cmd.stat_ld  = 1'b1;
            cmd.stat_val = STAT_CORRUPT;
            state_next   = ST_HDR;
          end else if (sts.unsup) begin
            cmd.stat_ld  = 1'b1;
            cmd.stat_val = STAT_UNSUPPORTED;
            state_next   = ST_HDR;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_next    = ST_DIV2;
          end
        end
      end
      ST_DIV2: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          cmd.stat_ld  = 1'b1;
          cmd.stat_val = STAT_SUCCESS;
          cmd.plen_ld  = 1'b1;
          state_next   = ST_HDR;
        end
      end
      ST_HDR: begin
        if (sts.out_ready) begin
          cmd.out_sel = OUT_HDR;
          cmd.last    = sts.plen_zero || eos_hold;
          cmd.cnt_op  = CNT_PLEN;
          if (eos_hold) begin
            cmd.clear_all = 1'b1;
            eos_hold_next = 1'b0;
            state_next    = ST_LEAD;
          end else begin
            state_next = sts.plen_zero ? ST_DRAIN : ST_DATA;
          end
        end
      end
      ST_NODATA: begin
        if (sts.out_ready) begin
          cmd.out_sel   = OUT_NODATA;
          cmd.last      = 1'b1;
          cmd.clear_all = 1'b1;
          state_next    = ST_LEAD;
        end
      end
      default: state_next = ST_DRAIN;
    endcase

    // end of stream: report a missing data chunk, else return to reset
    if (accept && end_of_stream && state_next != ST_MUL) begin
      if (cmd.out_sel == OUT_NONE && state_next != ST_DRAIN) begin
        state_next = ST_NODATA;
      end else begin
        cmd.clear_all = 1'b1;
        state_next    = ST_LEAD;
      end
    end
  end

endmodule

@@ rtl/wcsp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcsp_checker
// Port-level checks on the result stream of the parser.
// ----------------------------------------------------------------------------
module wcsp_checker
  import wcsp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [1:0]  status,
  input logic [31:0] payload_length,
  input logic [7:0]  data_byte,
  input logic        last
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(kind))
    else $error("stalled result beat changed");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> status == STAT_SUCCESS && payload_length == 32'd0)
    else $error("data beat carries header status");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HEADER && status != STAT_SUCCESS
      |-> last && payload_length == 32'd0)
    else $error("failed header not final");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HEADER && payload_length == 32'd0 |-> last)
    else $error("empty payload header not final");

endmodule

bind wav_chunk_stream_parser wcsp_checker u_wcsp_checker (.*);

@@ dv/wav_chunk_stream_parser_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_chunk_stream_parser_test
// Self-checking bench for the byte-serial WAV header parser.
// ----------------------------------------------------------------------------
// Whole WAV files are built as byte lists and fed one beat at a time. A
// directed table of files is walked first, then random files. Most random files
// are well formed and some are cut short or are plain noise. A cycle-free
// parser model predicts every result beat from the accepted input beats, and
// the output monitor compares each result beat field by field.
// ----------------------------------------------------------------------------
module wav_chunk_stream_parser_test;
  import wcsp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [1:0]  status;
  logic [15:0] format_code;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] sample_bits;
  logic [31:0] payload_length;
  logic [7:0]  data_byte;
  logic        last;

  wav_chunk_stream_parser dut (.*);

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] code;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] plen;
    logic [7:0]  dbyte;
    logic        fin;
  } wav_beat_t;

  // one stream byte, plus the header status typed in for a directed file
  typedef struct {
    logic [7:0] b;
    bit         eos;
    int         want;
  } stream_byte_t;

  // one file of the directed table; want < 0 leaves the status to the model
  typedef struct {
    logic [15:0] code;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] fmt_len;
    int          junk;
    logic [31:0] dsize;
    int          dbytes;
    int          tail;
    int          cut;
    int          want;
  } file_row_t;

  wav_beat_t    expected_beats[$];
  stream_byte_t stream_q[$];
  logic [7:0]   file_bytes[$];
  int           errors = 0;
  bit           idle_on = 1'b1;
  int           hold_left = 0;

  // ---- parser model state ----
  state_t      ph;
  logic [1:0]  fld_idx;
  logic [31:0] acc, remain, tag, fmt_len;
  logic [15:0] h_code, h_chans, h_align, h_bits;
  logic [31:0] h_rate, h_brate;

  function automatic void model_reset();
    ph = ST_LEAD;
    fld_idx = '0;
    acc = '0;
    remain = '0;
    tag = '0;
    fmt_len = '0;
    h_code = '0;
    h_chans = '0;
    h_rate = '0;
    h_brate = '0;
    h_align = '0;
    h_bits = '0;
  endfunction

  // Accumulate one little-endian byte; return 1 with the value once complete.
  function automatic bit take_field(input logic [7:0] b, input int len,
                                    output logic [31:0] v);
    acc = acc | ({24'd0, b} << (8 * fld_idx));
    v = acc;
    if (int'(fld_idx) + 1 >= len) begin
      acc = '0;
      fld_idx = '0;
      return 1'b1;
    end
    fld_idx = fld_idx + 2'd1;
    return 1'b0;
  endfunction

  function automatic wav_beat_t held_beat(input logic k, input logic [1:0] st,
                                          input logic [31:0] pl, input logic [7:0] db,
                                          input logic f);
    wav_beat_t r;
    r = '{k, st, h_code, h_chans, h_rate, h_brate, h_align, h_bits, pl, db, f};
    return r;
  endfunction

  // Advance the parser model by one accepted byte; return 1 if a beat results.
  function automatic bit parse_byte(input logic [7:0] b, input bit eos,
                                    output wav_beat_t r);
    logic [31:0] v, fbits, frame, pl;
    logic [1:0]  st;
    bit          got;
    got = 1'b0;
    r = '0;
    case (ph)
      ST_LEAD: begin
        remain = remain + 1;
        if (remain >= FMT_BASE) begin
          remain = '0;
          ph = ST_FMTLEN;
        end
      end
      ST_FMTLEN: if (take_field(b, 4, v)) begin
        fmt_len = v;
        ph = ST_FTYPE;
      end
      ST_FTYPE: if (take_field(b, 2, v)) begin
        h_code = v[15:0];
        ph = ST_CHANS;
      end
      ST_CHANS: if (take_field(b, 2, v)) begin
        h_chans = v[15:0];
        ph = ST_RATE;
      end
      ST_RATE: if (take_field(b, 4, v)) begin
        h_rate = v;
        ph = ST_BRATE;
      end
      ST_BRATE: if (take_field(b, 4, v)) begin
        h_brate = v;
        ph = ST_ALIGN;
      end
      ST_ALIGN: if (take_field(b, 2, v)) begin
        h_align = v[15:0];
        ph = ST_BITS;
      end
      ST_BITS: if (take_field(b, 2, v)) begin
        h_bits = v[15:0];
        remain = fmt_len - FMT_BASE;
        ph = (remain == 0) ? ST_CHUNKID : ST_FMTSKIP;
      end
      ST_FMTSKIP, ST_CHUNKSKIP: begin
        remain = remain - 1;
        if (remain == 0) ph = ST_CHUNKID;
      end
      ST_CHUNKID: if (take_field(b, 4, v)) begin
        tag = v;
        ph = ST_CHUNKSIZE;
      end
      ST_CHUNKSIZE: if (take_field(b, 4, v)) begin
        if (tag == TAG_DATA) begin
          fbits = {16'd0, h_chans} * {16'd0, h_bits};
          st = STAT_SUCCESS;
          pl = '0;
          if (fbits == 0 || ((fbits / 8) % {16'd0, h_chans}) != 0) begin
            st = STAT_CORRUPT;
          end else if (h_code != FMT_PCM ||
                       (h_bits != BITS_8 && h_bits != BITS_16 && h_bits != BITS_32)) begin
            st = STAT_UNSUPPORTED;
          end else begin
            frame = fbits / 8;
            pl = (v / frame) * frame;
          end
          remain = pl;
          r = held_beat(KIND_HEADER, st, pl, 8'd0, (pl == 0) || eos);
          got = 1'b1;
          ph = (pl == 0) ? ST_DRAIN : ST_DATA;
        end else begin
          remain = v;
          ph = (v == 0) ? ST_CHUNKID : ST_CHUNKSKIP;
        end
      end
      ST_DATA: begin
        remain = remain - 1;
        r = held_beat(KIND_DATA, STAT_SUCCESS, 32'd0, b, (remain == 0) || eos);
        got = 1'b1;
        if (remain == 0) ph = ST_DRAIN;
      end
      default: ph = ST_DRAIN;
    endcase
    if (eos) begin
      if (!got && ph != ST_DRAIN && ph != ST_DATA) begin
        r = held_beat(KIND_HEADER, STAT_NO_DATA, 32'd0, 8'd0, 1'b1);
        got = 1'b1;
      end
      model_reset();
    end
    return got;
  endfunction

  // ---- file builder ----
  function automatic void put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  // Build one file and queue its bytes; the final kept byte carries end_of_stream.
  function automatic void add_file(input file_row_t f);
    logic [31:0] jt;
    int          js, keep;
    file_bytes.delete();
    for (int i = 0; i < 16; i++) put_le($urandom, 1);
    put_le(f.fmt_len, 4);
    put_le(f.code, 2);
    put_le(f.chans, 2);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(f.bits, 2);
    // extra fmt bytes, only for short excess lengths
    if (f.fmt_len > FMT_BASE && f.fmt_len < 32'd64)
      for (int i = 0; i < int'(f.fmt_len - FMT_BASE); i++) put_le($urandom, 1);
    for (int j = 0; j < f.junk; j++) begin
      do jt = $urandom; while (jt == TAG_DATA);
      js = $urandom_range(0, 6);
      put_le(jt, 4);
      put_le(js, 4);
      for (int i = 0; i < js; i++) put_le($urandom, 1);
    end
    put_le(TAG_DATA, 4);
    put_le(f.dsize, 4);
    for (int i = 0; i < f.dbytes + f.tail; i++) put_le($urandom, 1);
    keep = (f.cut > 0 && f.cut < file_bytes.size()) ? f.cut : file_bytes.size();
    for (int i = 0; i < keep; i++)
      stream_q.push_back('{file_bytes[i], i == keep - 1, f.want});
  endfunction

  // Random file: mostly well formed PCM, some odd headers, some cut short.
  function automatic file_row_t random_file();
    file_row_t   f;
    logic [15:0] chans_pick[5];
    logic [15:0] bits_pick[6];
    int          ds;
    chans_pick = '{16'd1, 16'd2, 16'd3, 16'd4, 16'($urandom)};
    bits_pick = '{BITS_8, BITS_16, BITS_32, 16'd24, 16'd0, 16'($urandom)};
    f.code = ($urandom_range(0, 9) < 8) ? FMT_PCM : 16'($urandom);
    f.chans = chans_pick[$urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : 4];
    f.bits = bits_pick[$urandom_range(0, 9) < 8 ? $urandom_range(0, 2)
                                                 : $urandom_range(3, 5)];
    f.fmt_len = FMT_BASE + $urandom_range(0, 4);
    f.junk = $urandom_range(0, 2);
    ds = $urandom_range(0, 30);
    f.dsize = ds;
    f.dbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30) : ds;
    f.tail = $urandom_range(0, 3);
    f.cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : 0;
    f.want = -1;
    return f;
  endfunction

  // Directed files: no-data ends, every status, extremes of the header fields.
  file_row_t directed_files[] = '{
    // code    chans    bits     fmt_len   junk dsize          dbytes tail cut want
    '{16'd1,    16'd1,    16'd8,    32'd16, 0, 32'd4,          4, 0,  1,
      STAT_NO_DATA},
    '{16'd1,    16'd1,    16'd8,    32'd16, 0, 32'd4,          4, 0, 30,
      STAT_NO_DATA},
    '{16'd1,    16'd1,    16'd8,    32'd16, 0, 32'd4,          4, 0,  0,
      STAT_SUCCESS},
    '{16'd1,    16'd2,    16'd16,   32'd16, 1, 32'd7,          7, 2,  0, -1},
    '{16'd1,    16'd0,    16'd16,   32'd16, 0, 32'd8,          0, 2,  0,
      STAT_CORRUPT},
    '{16'd1,    16'd2,    16'd12,   32'd16, 0, 32'd8,          0, 1,  0,
      STAT_CORRUPT},
    '{16'd1,    16'd5,    16'd0,    32'd16, 0, 32'd8,          0, 0,  0,
      STAT_CORRUPT},
    '{16'd3,    16'd1,    16'd32,   32'd16, 0, 32'd8,          0, 1,  0,
      STAT_UNSUPPORTED},
    '{16'd1,    16'd3,    16'd24,   32'd16, 0, 32'd9,          0, 1,  0,
      STAT_UNSUPPORTED},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd18, 2, 32'hFFFF_FFFF,  0, 2,  0, -1},
    '{16'd1,    16'd1,    16'd8,    32'd16, 0, 32'd0,          0, 3,  0,
      STAT_SUCCESS},
    '{16'd1,    16'd1,    16'd16,   32'd16, 0, 32'd8,          0, 0,  0, -1},
    '{16'd1,    16'd1,    16'd8,    32'd16, 0, 32'hFFFF_FFFF,  6, 0,  0, -1},
    '{16'd1,    16'd2,    16'd32,   32'd20, 2, 32'd17,        17, 2,  0, -1},
    '{16'd1,    16'd1,    16'd8,    32'd0,  0, 32'd4,          4, 0, 60,
      STAT_NO_DATA},
    '{16'd1,    16'd2,    16'd16,   32'd16, 0, 32'd3,          3, 1,  0,
      STAT_SUCCESS}
  };

  // ---- input driver ----
  task automatic send_stream();
    stream_byte_t sb;
    wav_beat_t    r;
    while (stream_q.size() != 0) begin
      sb = stream_q.pop_front();
      // drop valid for a random burst now and then
      if (idle_on && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte <= sb.b;
      end_of_stream <= sb.eos;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (parse_byte(sb.b, sb.eos, r)) begin
        if (r.kind == KIND_HEADER && sb.want >= 0) r.status = 2'(sb.want);
        expected_beats.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // ---- output monitor and stall generator ----
  always @(posedge clk) begin
    wav_beat_t e;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat, kind %0b status %0d", $time, kind, status);
          errors++;
        end else begin
          e = expected_beats.pop_front();
          check_field("kind", e.kind, kind);
          check_field("status", e.status, status);
          check_field("format_code", e.code, format_code);
          check_field("channel_count", e.chans, channel_count);
          check_field("sample_rate", e.rate, sample_rate);
          check_field("byte_rate", e.brate, byte_rate);
          check_field("block_align", e.align, block_align);
          check_field("sample_bits", e.bits, sample_bits);
          check_field("payload_length", e.plen, payload_length);
          check_field("data_byte", e.dbyte, data_byte);
          check_field("last", e.fin, last);
        end
      end
      // hold the result side for random bursts
      if (hold_left > 0) hold_left--;
      else if (idle_on && $urandom_range(0, 9) == 0) hold_left = $urandom_range(1, 13);
      out_stall <= (hold_left > 0);
    end
  end

  // ---- main sequence ----
  initial begin
    int nfiles, waited;
    model_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_files[i]) add_file(directed_files[i]);
    waited = stream_q.size();
    send_stream();

    // let the parser drain completely before going on
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);

    // the directed bytes count toward the total
    nfiles = 0;
    for (int sent = waited; sent < 750 || nfiles < 2; nfiles++) begin
      // quiet tail: no idling on either side
      if (sent > 600) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        // noise file: random bytes, then end of stream
        file_bytes.delete();
        waited = $urandom_range(1, 40);
        for (int i = 0; i < waited; i++)
          stream_q.push_back('{8'($urandom), i == waited - 1, -1});
      end else begin
        add_file(random_file());
      end
      sent += stream_q.size();
      send_stream();
    end
    in_valid <= 1'b0;
    end_of_stream <= 1'b0;

    waited = 0;
    while (expected_beats.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time,
               expected_beats.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ wav_chunk_stream_parser.f @@
rtl/wcsp_pkg.sv
rtl/wcsp_div.sv
rtl/wcsp_dpath.sv
rtl/wcsp_ctrl.sv
rtl/wav_chunk_stream_parser.sv
rtl/wcsp_checker.sv
dv/wav_chunk_stream_parser_test.sv
